@@ design/mksq_pkg.sv @@
// ----------------------------------------------------------------------------
// mksq_pkg: shared types and codes for the sorted priority queue
// Record layout, per-cycle command to the cell chain, opcodes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mksq_pkg;

	localparam int KEY_W    = 8;
	localparam int PRICE_W  = 24;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POPPED     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROP_FULL  = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [PRICE_W-1:0]  price;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// broadcast to every cell in the cycle a word is accepted
	typedef struct packed {
		logic   ins_en;
		logic   pop_en;
		entry_t entry;
	} cmd_t;

endpackage

`default_nettype wire

@@ design/mksq_cell.sv @@
// ----------------------------------------------------------------------------
// mksq_cell: one slot of the sorted chain
// Holds one record; on insert it keeps, takes the new record or takes its
// left neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mksq_cell (
	input  wire logic           clk,
	input  wire mksq_pkg::cmd_t cmd,
	input  wire logic           occupied,
	input  wire logic           left_move,
	input  wire mksq_pkg::entry_t left_entry,
	input  wire mksq_pkg::entry_t right_entry,
	output logic                move,
	output mksq_pkg::entry_t    entry
);

	mksq_pkg::entry_t entry_q;

	// equal keys stay ahead of the new record
	assign move  = !(occupied && (entry_q.key <= cmd.entry.key));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en && move) begin
			entry_q <= left_move ? left_entry : cmd.entry;
		end else if (cmd.pop_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

@@ design/min_key_sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// min_key_sorted_priority_queue_unit: bounded min-key priority queue
// A row of cells kept in ascending key order; insert shifts the tail right,
// pop shifts everything left and returns the head.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// in       in   in_valid / in_ready     operation, priority_key, price_cents,
//                                       record_handle
// out      out  out_valid / out_ready   status, out_key, out_price_cents,
//                                       out_handle, occupancy
//
// all cells update in the accept cycle, and the result
// sits in the output register on the next cycle.
// a new word is taken while the result register is empty or being drained,
// so a word per cycle is sustained when out_ready stays high.
// arst_n clears the entry count and the output valid; slot contents are
// left as they are and only slots below the count ever reach the output.
// ----------------------------------------------------------------------------
`default_nettype none

module min_key_sorted_priority_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            operation,
	input  wire logic [mksq_pkg::KEY_W-1:0]      priority_key,
	input  wire logic [mksq_pkg::PRICE_W-1:0]    price_cents,
	input  wire logic [mksq_pkg::HANDLE_W-1:0]   record_handle,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [mksq_pkg::STATUS_W-1:0]        status,
	output logic [mksq_pkg::KEY_W-1:0]           out_key,
	output logic [mksq_pkg::PRICE_W-1:0]         out_price_cents,
	output logic [mksq_pkg::HANDLE_W-1:0]        out_handle,
	output logic [mksq_pkg::OCC_W-1:0]           occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	logic [mksq_pkg::STATUS_W-1:0] status_q;
	mksq_pkg::entry_t    out_entry_q;
	logic [CNT_W-1:0]    occ_q;

	logic                accept;
	logic                full;
	logic                empty;
	mksq_pkg::cmd_t      cmd;
	mksq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
	logic                cell_move  [QUEUE_DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		cmd.ins_en       = accept && (operation == mksq_pkg::OP_INSERT) && !full;
		cmd.pop_en       = accept && (operation == mksq_pkg::OP_POP) && !empty;
		cmd.entry.key    = priority_key;
		cmd.entry.price  = price_cents;
		cmd.entry.handle = record_handle;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic             left_move;
		mksq_pkg::entry_t left_entry;
		mksq_pkg::entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_move  = 1'b0;
			assign left_entry = cmd.entry;
		end else begin : g_body
			assign left_move  = cell_move[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_next
			assign right_entry = cell_entry[i+1];
		end

		mksq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (CNT_W'(i) < count_q),
			.left_move   (left_move),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.move        (cell_move[i]),
			.entry       (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.ins_en) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (operation == mksq_pkg::OP_INSERT) begin
				out_entry_q <= '0;
				if (full) begin
					status_q <= mksq_pkg::ST_DROP_FULL;
					occ_q    <= count_q;
				end else begin
					status_q <= mksq_pkg::ST_INSERTED;
					occ_q    <= count_q + 1'b1;
				end
			end else begin
				if (empty) begin
					status_q    <= mksq_pkg::ST_POP_EMPTY;
					out_entry_q <= '0;
					occ_q       <= count_q;
				end else begin
					status_q    <= mksq_pkg::ST_POPPED;
					out_entry_q <= cell_entry[0];
					occ_q       <= count_q - 1'b1;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign out_key         = out_entry_q.key;
	assign out_price_cents = out_entry_q.price;
	assign out_handle      = out_entry_q.handle;
	assign occupancy       = mksq_pkg::OCC_W'(occ_q);

endmodule

`default_nettype wire
